@@ hdl/line_to_thin_quad_expander_core_defines.svh @@
// Assertion macros shared by the line-to-quad expander checker.
`ifndef LINE_TO_THIN_QUAD_EXPANDER_CORE_DEFINES_SVH
`define LINE_TO_THIN_QUAD_EXPANDER_CORE_DEFINES_SVH

// A condition that holds at every clock edge outside reset.
`define LTTQ_ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// A condition that, once seen, implies another at the next clock edge.
`define LTTQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/lttq_pkg.sv @@
// Types and constants of the line-to-quad expander.
`default_nettype none

package lttq_pkg;

  localparam int unsigned CfgW = 31;

  typedef logic [1:0] opcode_t;
  localparam opcode_t OP_APPEND = 2'd0;
  localparam opcode_t OP_LINE   = 2'd1;
  localparam opcode_t OP_CLEAR  = 2'd2;
  localparam opcode_t OP_UNUSED = 2'd3;

  typedef logic [1:0] reg_index_t;
  localparam reg_index_t REG_HALF_WIDTH     = 2'd0;
  localparam reg_index_t REG_MIN_LENGTH     = 2'd1;
  localparam reg_index_t REG_PERP_THRESHOLD = 2'd2;

  localparam logic [30:0] HALF_WIDTH_RESET     = 31'd328;
  localparam logic [30:0] MIN_LENGTH_RESET     = 31'd7;
  localparam logic [16:0] PERP_THRESHOLD_RESET = 17'd66;

  typedef struct packed {
    opcode_t            opcode;
    logic [9:0]         first_index;
    logic [9:0]         second_index;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [31:0]        vertex_number;
    logic [1:0]         corner;
    logic               last;
  } out_beat_t;

endpackage

`default_nettype wire

@@ hdl/lttq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lttq_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hdl/line_to_thin_quad_expander_core.sv @@
// Top level of the line-to-quad expander: vertex store, sequencer and shared divide/root unit.
//
//   channel  direction  handshake               beat
//   in       input      in_valid_i/in_ready_o   opcode, indices, vertex
//   out      output     out_valid_o/out_ready_i quad corner
//   cfg      input      cfg_we_i                register index and value
//
// A line is worked through by the shared unit, which retires one root bit or one quotient
// bit per cycle: the roots of the length and of the perpendicular (one more root when the
// alternate is needed), the unit-vector divisions and, for a nonzero perpendicular, the offset ones.
// The vertex store is not cleared after reset; a clear beat only resets the counters.
// The input stays not ready while a line is processed; a stalled corner holds its beat.
`default_nettype none

module line_to_thin_quad_expander_core #(
  parameter int unsigned MAX_VERTICES = 1024
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  lttq_pkg::in_beat_t     in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output lttq_pkg::out_beat_t    out_data_o,
  input  logic                   cfg_we_i,
  input  lttq_pkg::reg_index_t   cfg_index_i,
  input  logic [lttq_pkg::CfgW-1:0] cfg_wdata_i
);

  import lttq_pkg::*;

  localparam int unsigned AddrW  = $clog2(MAX_VERTICES);
  localparam int unsigned CountW = $clog2(MAX_VERTICES + 1);
  localparam logic [CountW-1:0] CountMax = CountW'(MAX_VERTICES);
  localparam logic [5:0] SqrtLast = 6'd32;
  localparam logic [5:0] DivLast  = 6'd47;

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b000000000001,
    ST_RD1    = 12'b000000000010,
    ST_RD2    = 12'b000000000100,
    ST_SUM_D  = 12'b000000001000,
    ST_SQRT_D = 12'b000000010000,
    ST_DIV_U  = 12'b000000100000,
    ST_SUM_P  = 12'b000001000000,
    ST_SQRT_P = 12'b000010000000,
    ST_MUL_Q  = 12'b000100000000,
    ST_LOAD_Q = 12'b001000000000,
    ST_DIV_Q  = 12'b010000000000,
    ST_EMIT   = 12'b100000000000
  } state_e;

  function automatic logic [31:0] mag33(logic signed [32:0] v);
    logic [32:0] t;
    t = v[32] ? -v : v;
    return t[31:0];
  endfunction

  function automatic logic [16:0] mag18(logic signed [17:0] v);
    logic [17:0] t;
    t = v[17] ? -v : v;
    return t[16:0];
  endfunction

  function automatic logic [31:0] sat33(logic [32:0] s);
    logic [31:0] r;
    if (s[32] != s[31]) begin
      r = s[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

  state_e state_q, state_d;
  logic [30:0] half_width_q, min_length_q;
  logic [16:0] perp_thr_q;
  logic [CountW-1:0] loaded_q;
  logic [31:0] emitted_q;
  logic out_valid_q;
  out_beat_t out_q;

  logic [9:0] i2_q;
  logic signed [31:0] v1_q [3];
  logic signed [31:0] v2_q [3];
  logic signed [32:0] d_q [3];
  logic signed [17:0] u_q [3];
  logic signed [17:0] p_q [3];
  logic signed [31:0] q_q [3];
  logic [16:0] plen_q;
  logic alt_q;
  logic [1:0] k_q;
  logic [5:0] cnt_q;
  logic [63:0] prod_q;
  logic [65:0] sum_q;
  logic [65:0] src_q;
  logic [34:0] rem_q;
  logic [47:0] acc_q;
  logic [32:0] den_q;
  logic sqrt_q;

  logic in_fire, idx_ok, store_we, out_load, unit_run, unit_last;
  logic [AddrW-1:0] store_raddr;
  logic [95:0] store_rdata;
  logic signed [31:0] rd_c [3];
  logic [1:0] k_sel, k_next;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [65:0] sq_total;
  logic [36:0] cand, trial, diff;
  logic ge;
  logic [34:0] rem_next;
  logic [47:0] acc_next;
  logic [32:0] root;
  out_beat_t corner_beat;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign idx_ok     = (32'(in_data_i.first_index) < 32'(loaded_q)) &&
                      (32'(in_data_i.second_index) < 32'(loaded_q));
  assign store_we   = in_fire && (in_data_i.opcode == OP_APPEND) && (loaded_q != CountMax);
  assign store_raddr = (state_q == ST_RD1) ? AddrW'(i2_q) : AddrW'(in_data_i.first_index);

  lttq_ram #(
    .WIDTH(96),
    .DEPTH(MAX_VERTICES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (store_we),
    .waddr_i(loaded_q[AddrW-1:0]),
    .wdata_i({in_data_i.coord_x, in_data_i.coord_y, in_data_i.coord_z}),
    .raddr_i(store_raddr),
    .rdata_o(store_rdata)
  );

  assign rd_c[0] = store_rdata[95:64];
  assign rd_c[1] = store_rdata[63:32];
  assign rd_c[2] = store_rdata[31:0];

  assign k_sel  = (k_q == 2'd3) ? 2'd0 : k_q;
  assign k_next = k_q + 2'd1;

  always_comb begin
    if (state_q == ST_SUM_D) begin
      mul_a = mag33(d_q[k_sel]);
      mul_b = mag33(d_q[k_sel]);
    end else if (state_q == ST_SUM_P) begin
      mul_a = 32'(mag18(p_q[k_sel]));
      mul_b = 32'(mag18(p_q[k_sel]));
    end else begin
      mul_a = 32'(mag18(p_q[k_sel]));
      mul_b = 32'(half_width_q);
    end
  end

  assign prod     = mul_a * mul_b;
  assign sq_total = sum_q + 66'(prod_q);

  assign cand      = sqrt_q ? {rem_q, src_q[65:64]} : {1'b0, rem_q, src_q[65]};
  assign trial     = sqrt_q ? {acc_q[34:0], 2'b01} : {4'b0, den_q};
  assign ge        = (cand >= trial);
  assign diff      = cand - trial;
  assign rem_next  = ge ? diff[34:0] : cand[34:0];
  assign acc_next  = {acc_q[46:0], ge};
  assign root      = acc_next[32:0];
  assign unit_run  = (state_q == ST_SQRT_D) || (state_q == ST_SQRT_P) ||
                     (state_q == ST_DIV_U) || (state_q == ST_DIV_Q);
  assign unit_last = (cnt_q == (sqrt_q ? SqrtLast : DivLast));
  assign out_load  = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);

  always_comb begin
    logic signed [31:0] v;
    logic neg;
    logic [32:0] s;
    logic [31:0] c [3];
    neg = (k_q == 2'd0) || (k_q == 2'd3);
    for (int i = 0; i < 3; i++) begin
      v = k_q[1] ? v2_q[i] : v1_q[i];
      if (neg) begin
        s = {v[31], v} - {q_q[i][31], q_q[i]};
      end else begin
        s = {v[31], v} + {q_q[i][31], q_q[i]};
      end
      c[i] = sat33(s);
    end
    corner_beat.out_x         = c[0];
    corner_beat.out_y         = c[1];
    corner_beat.out_z         = c[2];
    corner_beat.vertex_number = emitted_q + 32'(k_q);
    corner_beat.corner        = k_q;
    corner_beat.last          = (k_q == 2'd3);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && (in_data_i.opcode == OP_LINE) && idx_ok) begin
          state_d = ST_RD1;
        end
      end
      ST_RD1:  state_d = ST_RD2;
      ST_RD2:  state_d = ST_SUM_D;
      ST_SUM_D: begin
        if (k_q == 2'd3) begin
          state_d = ST_SQRT_D;
        end
      end
      ST_SQRT_D: begin
        if (unit_last) begin
          state_d = (root <= 33'(min_length_q)) ? ST_IDLE : ST_DIV_U;
        end
      end
      ST_DIV_U: begin
        if (unit_last && (k_q == 2'd2)) begin
          state_d = ST_SUM_P;
        end
      end
      ST_SUM_P: begin
        if (k_q == 2'd3) begin
          state_d = ST_SQRT_P;
        end
      end
      ST_SQRT_P: begin
        if (unit_last) begin
          state_d = (!alt_q && (root < 33'(perp_thr_q))) ? ST_SUM_P : ST_MUL_Q;
        end
      end
      ST_MUL_Q: state_d = (plen_q == 17'd0) ? ST_EMIT : ST_LOAD_Q;
      ST_LOAD_Q: state_d = ST_DIV_Q;
      ST_DIV_Q: begin
        if (unit_last) begin
          state_d = (k_q == 2'd2) ? ST_EMIT : ST_MUL_Q;
        end
      end
      ST_EMIT: begin
        if (out_load && (k_q == 2'd3)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      half_width_q <= HALF_WIDTH_RESET;
      min_length_q <= MIN_LENGTH_RESET;
      perp_thr_q   <= PERP_THRESHOLD_RESET;
      loaded_q     <= '0;
      emitted_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_HALF_WIDTH:     half_width_q <= cfg_wdata_i;
          REG_MIN_LENGTH:     min_length_q <= cfg_wdata_i;
          REG_PERP_THRESHOLD: perp_thr_q   <= cfg_wdata_i[16:0];
          default: ;
        endcase
      end
      if (store_we) begin
        loaded_q <= loaded_q + CountW'(1);
      end else if (in_fire && (in_data_i.opcode == OP_CLEAR)) begin
        loaded_q <= '0;
      end
      if (in_fire && (in_data_i.opcode == OP_CLEAR)) begin
        emitted_q <= '0;
      end else if (out_load && (k_q == 2'd3)) begin
        emitted_q <= emitted_q + 32'd4;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      i2_q <= in_data_i.second_index;
    end
    if (unit_run) begin
      rem_q <= rem_next;
      acc_q <= acc_next;
      src_q <= sqrt_q ? {src_q[63:0], 2'b00} : {src_q[64:0], 1'b0};
      cnt_q <= cnt_q + 6'd1;
    end
    case (state_q)
      ST_RD1: begin
        for (int i = 0; i < 3; i++) begin
          v1_q[i] <= rd_c[i];
        end
      end
      ST_RD2: begin
        for (int i = 0; i < 3; i++) begin
          v2_q[i] <= rd_c[i];
          d_q[i]  <= {rd_c[i][31], rd_c[i]} - {v1_q[i][31], v1_q[i]};
        end
        k_q <= 2'd0;
      end
      ST_SUM_D, ST_SUM_P: begin
        prod_q <= prod;
        sum_q  <= (k_q == 2'd0) ? 66'd0 : sq_total;
        k_q    <= k_next;
        if (k_q == 2'd3) begin
          src_q  <= sq_total;
          rem_q  <= '0;
          acc_q  <= '0;
          cnt_q  <= '0;
          sqrt_q <= 1'b1;
        end
      end
      ST_SQRT_D: begin
        if (unit_last) begin
          src_q  <= {mag33(d_q[0]), 34'd0};
          den_q  <= root;
          rem_q  <= '0;
          acc_q  <= '0;
          cnt_q  <= '0;
          sqrt_q <= 1'b0;
          k_q    <= 2'd0;
        end
      end
      ST_DIV_U: begin
        if (unit_last) begin
          u_q[k_q] <= d_q[k_q][32] ? -18'(acc_next[16:0]) : 18'(acc_next[16:0]);
          if (k_q == 2'd2) begin
            p_q[0] <= -u_q[1];
            p_q[1] <= u_q[0];
            p_q[2] <= '0;
            alt_q  <= 1'b0;
            k_q    <= 2'd0;
          end else begin
            src_q <= {mag33(d_q[k_next]), 34'd0};
            rem_q <= '0;
            acc_q <= '0;
            cnt_q <= '0;
            k_q   <= k_next;
          end
        end
      end
      ST_SQRT_P: begin
        if (unit_last) begin
          k_q <= 2'd0;
          if (!alt_q && (root < 33'(perp_thr_q))) begin
            p_q[0] <= '0;
            p_q[1] <= -u_q[2];
            p_q[2] <= u_q[1];
            alt_q  <= 1'b1;
          end else begin
            plen_q <= root[16:0];
          end
        end
      end
      ST_MUL_Q: begin
        prod_q <= prod;
        if (plen_q == 17'd0) begin
          for (int i = 0; i < 3; i++) begin
            q_q[i] <= '0;
          end
          k_q <= 2'd0;
        end
      end
      ST_LOAD_Q: begin
        src_q  <= {prod_q[47:0], 18'd0};
        den_q  <= 33'(plen_q);
        rem_q  <= '0;
        acc_q  <= '0;
        cnt_q  <= '0;
        sqrt_q <= 1'b0;
      end
      ST_DIV_Q: begin
        if (unit_last) begin
          q_q[k_q] <= p_q[k_q][17] ? -32'(acc_next[30:0]) : 32'(acc_next[30:0]);
          k_q      <= (k_q == 2'd2) ? 2'd0 : k_next;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          out_q <= corner_beat;
          k_q   <= k_next;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ hdl/lttq_checker.sv @@
// Port-level checker for the line-to-quad expander, bound to the top level.
`default_nettype none
`include "line_to_thin_quad_expander_core_defines.svh"

module lttq_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input lttq_pkg::out_beat_t out_data_i
);

  import lttq_pkg::*;

  `LTTQ_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i,
    out_valid_i && $stable(out_data_i), "Stalled corner beat changed.")
  `LTTQ_ASSERT_HOLDS(a_last_on_corner3,
    !out_valid_i || (out_data_i.last == (out_data_i.corner == 2'd3)),
    "Last flag does not match corner three.")
  `LTTQ_ASSERT_NEXT(a_corner_step, out_valid_i && out_ready_i && !out_data_i.last,
    out_valid_i && (out_data_i.corner == $past(out_data_i.corner) + 2'd1),
    "Quad corners not consecutive.")
  `LTTQ_ASSERT_NEXT(a_number_step, out_valid_i && out_ready_i && !out_data_i.last,
    out_data_i.vertex_number == $past(out_data_i.vertex_number) + 32'd1,
    "Vertex numbers not consecutive.")
  `LTTQ_ASSERT_HOLDS(a_busy_in_quad, !(out_valid_i && !out_data_i.last) || !in_ready_i,
    "Input ready in the middle of a quad.")

endmodule

bind line_to_thin_quad_expander_core lttq_checker u_lttq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready_i (in_ready_o),
  .out_valid_i(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_i (out_data_o)
);

`default_nettype wire

@@ sim/line_to_thin_quad_expander_core_tb.sv @@
// Self-checking testbench of the line-to-quad expander: predicted corners against the block.
`default_nettype none

module line_to_thin_quad_expander_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lttq_pkg::*;

  localparam int unsigned StoreDepth = 1024;
  localparam int unsigned FillCount = 40;
  localparam int unsigned DrainCycles = 600;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_beat_t    in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_beat_t   out_data_o;
  logic        cfg_we_i;
  reg_index_t  cfg_index_i;
  logic [CfgW-1:0] cfg_wdata_i;

  line_to_thin_quad_expander_core #(.MAX_VERTICES(StoreDepth)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o, .cfg_we_i, .cfg_index_i, .cfg_wdata_i
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  logic signed [31:0] vtx_x [StoreDepth];
  logic signed [31:0] vtx_y [StoreDepth];
  logic signed [31:0] vtx_z [StoreDepth];
  int unsigned  loaded_vertices;
  logic [31:0]  emitted_vertices;
  logic [30:0]  half_width;
  logic [30:0]  min_length;
  logic [16:0]  perp_threshold;
  out_beat_t    corner_q [$];
  int unsigned  fail_count;
  int unsigned  send_gap_pct;
  int unsigned  recv_stall_pct;

  function automatic logic [33:0] floor_root(input logic [67:0] s);
    logic [67:0] rem;
    logic [67:0] trial;
    logic [33:0] root;
    rem = '0;
    root = '0;
    for (int k = 33; k >= 0; k--) begin
      rem = (rem << 2) | ((s >> (2 * k)) & 68'd3);
      trial = {32'd0, root, 2'b01};
      if (rem >= trial) begin
        rem = rem - trial;
        root = {root[32:0], 1'b1};
      end else begin
        root = {root[32:0], 1'b0};
      end
    end
    return root;
  endfunction

  function automatic longint vec_length(input longint a, input longint b, input longint c);
    logic [67:0] ma;
    logic [67:0] mb;
    logic [67:0] mc;
    ma = 68'(a < 0 ? -a : a);
    mb = 68'(b < 0 ? -b : b);
    mc = 68'(c < 0 ? -c : c);
    return longint'(floor_root(ma * ma + mb * mb + mc * mc));
  endfunction

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic void predict_beat(input in_beat_t b);
    longint d [3];
    longint u [3];
    longint p [3];
    longint q [3];
    longint ends [2][3];
    longint len;
    longint plen;
    longint sgn;
    out_beat_t o;
    case (b.opcode)
      OP_APPEND: begin
        if (loaded_vertices < StoreDepth) begin
          vtx_x[loaded_vertices] = b.coord_x;
          vtx_y[loaded_vertices] = b.coord_y;
          vtx_z[loaded_vertices] = b.coord_z;
          loaded_vertices++;
        end
      end
      OP_CLEAR: begin
        loaded_vertices = 0;
        emitted_vertices = '0;
      end
      OP_LINE: begin
        if (b.first_index < loaded_vertices && b.second_index < loaded_vertices) begin
          ends[0][0] = vtx_x[b.first_index];
          ends[0][1] = vtx_y[b.first_index];
          ends[0][2] = vtx_z[b.first_index];
          ends[1][0] = vtx_x[b.second_index];
          ends[1][1] = vtx_y[b.second_index];
          ends[1][2] = vtx_z[b.second_index];
          for (int i = 0; i < 3; i++) d[i] = ends[1][i] - ends[0][i];
          len = vec_length(d[0], d[1], d[2]);
          if (len > longint'(min_length)) begin
            for (int i = 0; i < 3; i++) u[i] = (d[i] * 65536) / len;
            p[0] = -u[1];
            p[1] = u[0];
            p[2] = 0;
            plen = vec_length(p[0], p[1], p[2]);
            if (plen < longint'(perp_threshold)) begin
              p[0] = 0;
              p[1] = -u[2];
              p[2] = u[1];
              plen = vec_length(p[0], p[1], p[2]);
            end
            for (int i = 0; i < 3; i++)
              q[i] = (plen == 0) ? 0 : (p[i] * longint'(half_width)) / plen;
            for (int k = 0; k < 4; k++) begin
              sgn = (k == 0 || k == 3) ? -1 : 1;
              o.out_x = clamp32(ends[k >> 1][0] + sgn * q[0]);
              o.out_y = clamp32(ends[k >> 1][1] + sgn * q[1]);
              o.out_z = clamp32(ends[k >> 1][2] + sgn * q[2]);
              o.vertex_number = emitted_vertices + 32'(k);
              o.corner = 2'(k);
              o.last = (k == 3);
              corner_q = {corner_q, o};
            end
            emitted_vertices = emitted_vertices + 32'd4;
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_beat(input in_beat_t b);
    logic rdy;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= b;
    do begin
      @(negedge clk_i);
      rdy = in_ready_o;
      @(posedge clk_i);
    end while (!rdy);
    predict_beat(b);
  endtask

  task automatic send_op(input opcode_t op, input int unsigned i1, input int unsigned i2,
                         input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
    in_beat_t b;
    b.opcode = op;
    b.first_index = 10'(i1);
    b.second_index = 10'(i2);
    b.coord_x = x;
    b.coord_y = y;
    b.coord_z = z;
    send_beat(b);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (corner_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [CfgW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_HALF_WIDTH:     half_width = val[30:0];
      REG_MIN_LENGTH:     min_length = val[30:0];
      REG_PERP_THRESHOLD: perp_threshold = val[16:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [30:0] hw, input logic [30:0] ml, input logic [16:0] pt);
    wait_idle();
    write_reg(REG_HALF_WIDTH, hw);
    write_reg(REG_MIN_LENGTH, ml);
    write_reg(REG_PERP_THRESHOLD, {14'd0, pt});
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(2000)) - 1000) <<< $urandom_range(16);
      2: return {$urandom_range(1) ? 2'b01 : 2'b10, 30'($urandom)};
      default: return 32'($signed($urandom_range(200)) - 100);
    endcase
  endfunction

  task automatic test_store_fill();
    for (int n = 0; n < FillCount; n++)
      send_op(OP_APPEND, $urandom, $urandom, rand_coord(), rand_coord(), rand_coord());
    send_op(OP_LINE, 0, FillCount - 1, $urandom, $urandom, $urandom);
    send_op(OP_LINE, FillCount - 1, 1, $urandom, $urandom, $urandom);
    send_op(OP_LINE, FillCount, 0, $urandom, $urandom, $urandom);
    send_op(OP_CLEAR, 0, 0, 0, 0, 0);
  endtask

  task automatic test_directed();
    send_op(OP_APPEND, 0, 0, 32'h0, 32'h0, 32'h0);
    send_op(OP_APPEND, 0, 0, 32'h0001_0000, 32'h0, 32'h0);
    send_op(OP_APPEND, 0, 0, 32'h0, 32'h0, 32'h0003_0000);
    send_op(OP_APPEND, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_op(OP_APPEND, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000);
    send_op(OP_APPEND, 0, 0, 32'd3, 32'd0, 32'd0);
    send_op(OP_LINE, 0, 1, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_op(OP_LINE, 0, 2, 0, 0, 0);
    send_op(OP_LINE, 3, 4, 0, 0, 0);
    send_op(OP_LINE, 4, 3, 0, 0, 0);
    send_op(OP_LINE, 0, 5, 0, 0, 0);
    send_op(OP_LINE, 1, 1, 0, 0, 0);
    send_op(OP_LINE, 0, 6, 0, 0, 0);
    send_op(OP_LINE, 1023, 0, 0, 0, 0);
    send_op(OP_LINE, 5, 0, 0, 0, 0);
    send_op(OP_UNUSED, 1023, 1023, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_op(OP_CLEAR, 1023, 1023, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_op(OP_LINE, 0, 0, 0, 0, 0);
  endtask

  task automatic test_random(input int unsigned count);
    int unsigned sent;
    int unsigned r;
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(99);
      if (r < 5) begin
        send_op(OP_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom);
        continue;
      end
      if (r < 12) begin
        send_op(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else if (loaded_vertices < 2 || r < 40) begin
        if (loaded_vertices > 0 && $urandom_range(3) == 0)
          send_op(OP_APPEND, $urandom, $urandom, vtx_x[loaded_vertices - 1],
                  vtx_y[loaded_vertices - 1], rand_coord());
        else
          send_op(OP_APPEND, $urandom, $urandom, rand_coord(), rand_coord(), rand_coord());
      end else if (r < 88) begin
        send_op(OP_LINE, $urandom_range(loaded_vertices - 1),
                $urandom_range(loaded_vertices - 1), $urandom, $urandom, $urandom);
      end else begin
        send_op(OP_LINE, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
      sent++;
    end
  endtask

  logic      seen_valid;
  out_beat_t seen_data;

  always @(negedge clk_i) begin
    seen_valid = out_valid_o;
    seen_data = out_data_o;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (seen_valid && out_ready_i) begin
        if (corner_q.size() == 0) begin
          $error("unexpected corner beat %p", seen_data);
          fail_count++;
        end else begin
          automatic out_beat_t e = corner_q.pop_front();
          if (seen_data.out_x !== e.out_x) begin
            $error("out_x expected %0d actual %0d", e.out_x, seen_data.out_x);
            fail_count++;
          end
          if (seen_data.out_y !== e.out_y) begin
            $error("out_y expected %0d actual %0d", e.out_y, seen_data.out_y);
            fail_count++;
          end
          if (seen_data.out_z !== e.out_z) begin
            $error("out_z expected %0d actual %0d", e.out_z, seen_data.out_z);
            fail_count++;
          end
          if (seen_data.vertex_number !== e.vertex_number) begin
            $error("vertex_number expected %0d actual %0d", e.vertex_number,
                   seen_data.vertex_number);
            fail_count++;
          end
          if (seen_data.corner !== e.corner) begin
            $error("corner expected %0d actual %0d", e.corner, seen_data.corner);
            fail_count++;
          end
          if (seen_data.last !== e.last) begin
            $error("last expected %0d actual %0d", e.last, seen_data.last);
            fail_count++;
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    out_ready_i <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= REG_HALF_WIDTH;
    cfg_wdata_i <= '0;
    loaded_vertices = 0;
    emitted_vertices = '0;
    half_width = HALF_WIDTH_RESET;
    min_length = MIN_LENGTH_RESET;
    perp_threshold = PERP_THRESHOLD_RESET;
    fail_count = 0;
    send_gap_pct = 11;
    recv_stall_pct = 65;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_store_fill();
    test_directed();
    set_regs(31'd0, 31'd0, 17'd0);
    test_directed();
    set_regs(31'h7fffffff, 31'h7fffffff, 17'd65536);
    test_directed();
    set_regs(31'd6554, 31'd100, 17'd65536);
    test_random(52);
    send_gap_pct = 65;
    recv_stall_pct = 11;
    set_regs(31'h0100_0000, 31'd0, 17'd40000);
    test_random(52);
    send_gap_pct = 0;
    recv_stall_pct = 0;
    set_regs(HALF_WIDTH_RESET, MIN_LENGTH_RESET, PERP_THRESHOLD_RESET);
    test_random(52);
    wait_idle();

    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
